/* rtl/twcc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// twcc_pkg
// Shared types and constants for the text window console cursor.
// ----------------------------------------------------------------------------
package twcc_pkg;

    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 25;
    localparam int TAB_STEP    = 4;

    localparam int ROW_W     = 5;
    localparam int COL_W     = 7;
    localparam int COL_REG_W = COL_W + 1;
    localparam int OFS_W     = 12;
    localparam int OFS_SUM_W = 14;
    localparam int CHAR_W    = 8;
    localparam int ATTR_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;
    localparam int MOD_CNT_W = $clog2(COL_REG_W);

    localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

    localparam logic REQ_SET_CURSOR = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIN_ROWS = 3'd0,
        REG_WIN_COLS = 3'd1,
        REG_ORG_ROW  = 3'd2,
        REG_ORG_COL  = 3'd3,
        REG_ATTR     = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [ROW_W-1:0]  rows;
        logic [COL_W-1:0]  cols;
        logic [ROW_W-1:0]  orow;
        logic [COL_W-1:0]  ocol;
        logic [ATTR_W-1:0] attr;
    } eff_cfg_t;

    typedef struct packed {
        logic load;
        logic mod_start;
        logic mod_step;
        logic exec;
        logic wrap_step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic need_mod;
        logic mod_last;
        logic wrap_need;
        logic out_free;
    } dp_sts_t;

endpackage
`default_nettype wire

/* rtl/twcc_cfg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// twcc_cfg
// Window registers and clamping to effective size and origin.
// ----------------------------------------------------------------------------
module twcc_cfg
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [twcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [twcc_pkg::CFG_DAT_W-1:0] cfg_data,
    output twcc_pkg::eff_cfg_t                  eff
);

    logic [twcc_pkg::ROW_W-1:0]  win_rows_reg;
    logic [twcc_pkg::COL_W-1:0]  win_cols_reg;
    logic [twcc_pkg::ROW_W-1:0]  org_row_reg;
    logic [twcc_pkg::COL_W-1:0]  org_col_reg;
    logic [twcc_pkg::ATTR_W-1:0] attr_reg;

    logic [twcc_pkg::ROW_W-1:0]  rows;
    logic [twcc_pkg::COL_W-1:0]  cols;
    logic [twcc_pkg::ROW_W:0]    row_end;
    logic [twcc_pkg::COL_W:0]    col_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_rows_reg <= twcc_pkg::ROW_W'(twcc_pkg::SCREEN_ROWS);
            win_cols_reg <= twcc_pkg::COL_W'(twcc_pkg::SCREEN_COLS);
            org_row_reg  <= '0;
            org_col_reg  <= '0;
            attr_reg     <= twcc_pkg::ATTR_W'(7);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                twcc_pkg::REG_WIN_ROWS: win_rows_reg <= cfg_data[twcc_pkg::ROW_W-1:0];
                twcc_pkg::REG_WIN_COLS: win_cols_reg <= cfg_data[twcc_pkg::COL_W-1:0];
                twcc_pkg::REG_ORG_ROW:  org_row_reg  <= cfg_data[twcc_pkg::ROW_W-1:0];
                twcc_pkg::REG_ORG_COL:  org_col_reg  <= cfg_data[twcc_pkg::COL_W-1:0];
                twcc_pkg::REG_ATTR:     attr_reg     <= cfg_data[twcc_pkg::ATTR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        priority if (win_rows_reg == '0)
            rows = twcc_pkg::ROW_W'(1);
        else if (win_rows_reg > twcc_pkg::ROW_W'(twcc_pkg::SCREEN_ROWS))
            rows = twcc_pkg::ROW_W'(twcc_pkg::SCREEN_ROWS);
        else
            rows = win_rows_reg;

        priority if (win_cols_reg == '0)
            cols = twcc_pkg::COL_W'(1);
        else if (win_cols_reg > twcc_pkg::COL_W'(twcc_pkg::SCREEN_COLS))
            cols = twcc_pkg::COL_W'(twcc_pkg::SCREEN_COLS);
        else
            cols = win_cols_reg;

        row_end = {1'b0, org_row_reg} + {1'b0, rows};
        col_end = {1'b0, org_col_reg} + {1'b0, cols};

        eff.rows = rows;
        eff.cols = cols;
        eff.orow = (row_end > (twcc_pkg::ROW_W+1)'(twcc_pkg::SCREEN_ROWS)) ? '0 : org_row_reg;
        eff.ocol = (col_end > (twcc_pkg::COL_W+1)'(twcc_pkg::SCREEN_COLS)) ? '0 : org_col_reg;
        eff.attr = attr_reg;
    end

endmodule
`default_nettype wire

/* rtl/twcc_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// twcc_ctrl
// Sequencer: accept, reduce, execute, wrap, hand off result.
// ----------------------------------------------------------------------------
module twcc_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire twcc_pkg::dp_sts_t  sts,
    output twcc_pkg::dp_cmd_t       cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_MOD  = 4'b0100,
        S_WRAP = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.need_mod)
                begin
                    cmd.mod_start = 1'b1;
                    state_next    = S_MOD;
                end
                else
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_WRAP;
                end
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (sts.mod_last)
                    state_next = S_EXEC;
            end
            S_WRAP:
            begin
                priority if (sts.wrap_need)
                    cmd.wrap_step = 1'b1;
                else if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

/* rtl/twcc_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// twcc_dp
// Cursor registers, bit-serial remainder lanes, offset and result register.
// ----------------------------------------------------------------------------
module twcc_dp
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire twcc_pkg::eff_cfg_t          eff,
    input  wire twcc_pkg::dp_cmd_t           cmd,
    output twcc_pkg::dp_sts_t                sts,
    input  wire logic                        req_type,
    input  wire logic [twcc_pkg::CHAR_W-1:0] char_code,
    input  wire logic [twcc_pkg::ROW_W-1:0]  set_row,
    input  wire logic [twcc_pkg::COL_W-1:0]  set_col,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic                             write_valid,
    output logic [twcc_pkg::OFS_W-1:0]       cell_offset,
    output logic [twcc_pkg::CHAR_W-1:0]      cell_char,
    output logic [twcc_pkg::ATTR_W-1:0]      cell_attr,
    output logic [twcc_pkg::ROW_W-1:0]       cursor_row,
    output logic [twcc_pkg::COL_W-1:0]       cursor_col
);

    localparam int RW = twcc_pkg::ROW_W;
    localparam int CW = twcc_pkg::COL_W;
    localparam int CRW = twcc_pkg::COL_REG_W;
    localparam int SW = twcc_pkg::OFS_SUM_W;

    logic [RW-1:0]                  row_reg, row_next;
    logic [CRW-1:0]                 col_reg, col_next;
    logic                           req_reg;
    logic [twcc_pkg::CHAR_W-1:0]    char_reg;
    logic                           wr_reg, wr_next;
    logic [twcc_pkg::OFS_W-1:0]     ofs_reg, ofs_next;

    logic [RW-1:0]                  mrow_rem_reg;
    logic [CW-1:0]                  mcol_rem_reg;
    logic [CRW-1:0]                 mrow_dvd_reg;
    logic [CRW-1:0]                 mcol_dvd_reg;
    logic [twcc_pkg::MOD_CNT_W-1:0] mod_cnt_reg;

    logic                           out_valid_reg;
    logic                           out_wr_reg;
    logic [twcc_pkg::OFS_W-1:0]     out_ofs_reg;
    logic [twcc_pkg::CHAR_W-1:0]    out_char_reg;
    logic [twcc_pkg::ATTR_W-1:0]    out_attr_reg;
    logic [RW-1:0]                  out_row_reg;
    logic [CW-1:0]                  out_col_reg;

    logic [CRW-1:0]                 cols_ext;
    logic [RW:0]                    row_plus;
    logic [RW-1:0]                  row_inc;
    logic [RW-1:0]                  row_dec;
    logic [RW:0]                    mrow_t;
    logic [RW:0]                    mrow_r;
    logic [CW:0]                    mcol_t;
    logic [CW:0]                    mcol_r;
    logic [RW:0]                    line;
    logic [SW-1:0]                  pos;
    logic [twcc_pkg::OFS_W-1:0]     ofs_calc;

    assign cols_ext = {1'b0, eff.cols};
    assign row_plus = {1'b0, row_reg} + (RW+1)'(1);
    assign row_inc  = (row_plus >= {1'b0, eff.rows}) ? '0 : row_plus[RW-1:0];
    assign row_dec  = (row_reg == '0) ? (eff.rows - RW'(1)) : (row_reg - RW'(1));

    // restoring remainder, one dividend bit per cycle
    assign mrow_t = {mrow_rem_reg, mrow_dvd_reg[CRW-1]};
    assign mrow_r = (mrow_t >= {1'b0, eff.rows}) ? (mrow_t - {1'b0, eff.rows}) : mrow_t;
    assign mcol_t = {mcol_rem_reg, mcol_dvd_reg[CRW-1]};
    assign mcol_r = (mcol_t >= cols_ext) ? (mcol_t - cols_ext) : mcol_t;

    assign line     = {1'b0, eff.orow} + {1'b0, row_reg};
    assign pos      = SW'(line) * SW'(twcc_pkg::SCREEN_COLS) + SW'(eff.ocol) + SW'(col_reg);
    assign ofs_calc = {pos[twcc_pkg::OFS_W-2:0], 1'b0};

    assign sts.need_mod  = (row_reg >= eff.rows) || (col_reg >= cols_ext);
    assign sts.mod_last  = (mod_cnt_reg == twcc_pkg::MOD_CNT_W'(CRW - 1));
    assign sts.wrap_need = (col_reg >= cols_ext);
    assign sts.out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        wr_next  = wr_reg;
        ofs_next = ofs_reg;
        priority if (cmd.load)
        begin
            wr_next  = 1'b0;
            ofs_next = '0;
            if (req_type == twcc_pkg::REQ_SET_CURSOR)
            begin
                row_next = set_row;
                col_next = {1'b0, set_col};
            end
        end
        else if (cmd.mod_step && sts.mod_last)
        begin
            row_next = mrow_r[RW-1:0];
            col_next = {1'b0, mcol_r[CW-1:0]};
        end
        else if (cmd.exec && (req_reg != twcc_pkg::REQ_SET_CURSOR))
        begin
            unique case (char_reg)
                twcc_pkg::CH_LF:
                begin
                    row_next = row_inc;
                    col_next = '0;
                end
                twcc_pkg::CH_CR:
                    col_next = '0;
                twcc_pkg::CH_BS:
                begin
                    if (col_reg != '0)
                        col_next = col_reg - CRW'(1);
                    else
                    begin
                        col_next = cols_ext - CRW'(1);
                        row_next = row_dec;
                    end
                end
                twcc_pkg::CH_TAB:
                    col_next = col_reg + CRW'(twcc_pkg::TAB_STEP);
                twcc_pkg::CH_NUL: ;
                default:
                begin
                    wr_next  = 1'b1;
                    ofs_next = ofs_calc;
                    col_next = col_reg + CRW'(1);
                end
            endcase
        end
        else if (cmd.wrap_step)
        begin
            col_next = col_reg - cols_ext;
            row_next = row_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            col_reg       <= '0;
            mod_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
            if (cmd.mod_start)
                mod_cnt_reg <= '0;
            else if (cmd.mod_step)
                mod_cnt_reg <= mod_cnt_reg + twcc_pkg::MOD_CNT_W'(1);
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_reg  <= wr_next;
        ofs_reg <= ofs_next;
        if (cmd.load)
        begin
            req_reg  <= req_type;
            char_reg <= char_code;
        end
        if (cmd.mod_start)
        begin
            mrow_rem_reg <= '0;
            mcol_rem_reg <= '0;
            mrow_dvd_reg <= CRW'(row_reg);
            mcol_dvd_reg <= col_reg;
        end
        else if (cmd.mod_step)
        begin
            mrow_rem_reg <= mrow_r[RW-1:0];
            mcol_rem_reg <= mcol_r[CW-1:0];
            mrow_dvd_reg <= {mrow_dvd_reg[CRW-2:0], 1'b0};
            mcol_dvd_reg <= {mcol_dvd_reg[CRW-2:0], 1'b0};
        end
        if (cmd.out_load)
        begin
            out_wr_reg   <= wr_reg;
            out_ofs_reg  <= ofs_reg;
            out_char_reg <= wr_reg ? char_reg : '0;
            out_attr_reg <= wr_reg ? eff.attr : '0;
            out_row_reg  <= row_reg;
            out_col_reg  <= col_reg[CW-1:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign write_valid = out_wr_reg;
    assign cell_offset = out_ofs_reg;
    assign cell_char   = out_char_reg;
    assign cell_attr   = out_attr_reg;
    assign cursor_row  = out_row_reg;
    assign cursor_col  = out_col_reg;

endmodule
`default_nettype wire

/* rtl/text_window_console_cursor_top.sv */
`default_nettype none
// Sequence: an accepted request is loaded, executed in S_EXEC and its result
// registered from S_WRAP once the output is free; a tab that wraps adds a wrap
// step per wrapped row (up to TAB_STEP). When the cursor or a set-cursor value
// is outside the window, a bit-serial remainder pass in S_MOD and a return to
// S_EXEC precede execution. in_stall blocks requests until S_IDLE returns.
// Reset: cursor at (0,0), window 25x80 at origin (0,0), attribute 0x07.
// ----------------------------------------------------------------------------
// text_window_console_cursor_top
// Text window console cursor: cursor tracking and cell write generation.
// ----------------------------------------------------------------------------
module text_window_console_cursor_top
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [twcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [twcc_pkg::CFG_DAT_W-1:0] cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           req_type,
    input  wire logic [twcc_pkg::CHAR_W-1:0]    char_code,
    input  wire logic [twcc_pkg::ROW_W-1:0]     set_row,
    input  wire logic [twcc_pkg::COL_W-1:0]     set_col,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic                                write_valid,
    output logic [twcc_pkg::OFS_W-1:0]          cell_offset,
    output logic [twcc_pkg::CHAR_W-1:0]         cell_char,
    output logic [twcc_pkg::ATTR_W-1:0]         cell_attr,
    output logic [twcc_pkg::ROW_W-1:0]          cursor_row,
    output logic [twcc_pkg::COL_W-1:0]          cursor_col
);

    twcc_pkg::eff_cfg_t eff;
    twcc_pkg::dp_cmd_t  cmd;
    twcc_pkg::dp_sts_t  sts;

    twcc_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .eff       (eff)
    );

    twcc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    twcc_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .eff         (eff),
        .cmd         (cmd),
        .sts         (sts),
        .req_type    (req_type),
        .char_code   (char_code),
        .set_row     (set_row),
        .set_col     (set_col),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .write_valid (write_valid),
        .cell_offset (cell_offset),
        .cell_char   (cell_char),
        .cell_attr   (cell_attr),
        .cursor_row  (cursor_row),
        .cursor_col  (cursor_col)
    );

endmodule
`default_nettype wire

/* tb/text_window_console_cursor_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_window_console_cursor_top_tb
// Self-checking bench for the console cursor: a directed table of requests
// and window settings, then randomized character streams under several
// window settings and idle patterns. Every result is compared field by field
// against its directed table entry or an in-bench cursor predictor.
// ----------------------------------------------------------------------------
module text_window_console_cursor_top_tb;

    import twcc_pkg::*;

    localparam logic REQ_CHAR        = ~REQ_SET_CURSOR;
    localparam int   NUM_PHASES      = 8;
    localparam int   ITEMS_PER_PHASE = 250;
    localparam int   HOLD_CYCLES     = 64;
    localparam int   SETTLE_CYCLES   = 20;
    localparam int   DRAIN_LIMIT     = 20000;
    localparam int   MAX_REPORTS     = 100;
    localparam int   PLAN_LEN        = 39;

    typedef struct {
        logic              wr;
        logic [OFS_W-1:0]  ofs;
        logic [CHAR_W-1:0] ch;
        logic [ATTR_W-1:0] attr;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } cell_result_t;

    typedef enum {P_CFG, P_PRED, P_TYPED} plan_kind_t;

    typedef struct {
        plan_kind_t        kind;
        cfg_idx_t          idx;
        logic [7:0]        val;
        logic              req;
        logic [ROW_W-1:0]  srow;
        logic [COL_W-1:0]  scol;
        cell_result_t      want;
    } plan_row_t;

    localparam cell_result_t NO_CELL = '{1'b0, 12'd0, 8'd0, 8'd0, 5'd0, 7'd0};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DAT_W-1:0]  cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  req_type = 1'b0;
    logic [CHAR_W-1:0]     char_code = '0;
    logic [ROW_W-1:0]      set_row = '0;
    logic [COL_W-1:0]      set_col = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  write_valid;
    logic [OFS_W-1:0]      cell_offset;
    logic [CHAR_W-1:0]     cell_char;
    logic [ATTR_W-1:0]     cell_attr;
    logic [ROW_W-1:0]      cursor_row;
    logic [COL_W-1:0]      cursor_col;

    text_window_console_cursor_top dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .char_code   (char_code),
        .set_row     (set_row),
        .set_col     (set_col),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .write_valid (write_valid),
        .cell_offset (cell_offset),
        .cell_char   (cell_char),
        .cell_attr   (cell_attr),
        .cursor_row  (cursor_row),
        .cursor_col  (cursor_col)
    );

    always #5 clk = ~clk;

    // predictor state
    logic [ROW_W-1:0]  win_rows_reg = 5'd25;
    logic [COL_W-1:0]  win_cols_reg = 7'd80;
    logic [ROW_W-1:0]  org_row_reg  = 5'd0;
    logic [COL_W-1:0]  org_col_reg  = 7'd0;
    logic [ATTR_W-1:0] attr_reg     = 8'h07;
    int                cur_row = 0;
    int                cur_col = 0;

    cell_result_t expected_cells [$];

    int errors = 0;
    int n_items = 0;
    int n_checked = 0;
    int n_writes = 0;
    int n_settings = 0;
    int send_idle_pct = 34;
    int recv_idle_pct = 47;
    int hold_asks = 0;
    int holds_done = 0;
    int hold_left = 0;

    plan_row_t plan [PLAN_LEN] = '{
        '{P_TYPED, REG_WIN_ROWS, 8'h41,  REQ_CHAR, 5'd0, 7'd0,
          '{1'b1, 12'd0, 8'h41, 8'h07, 5'd0, 7'd1}},
        '{P_TYPED, REG_WIN_ROWS, 8'h00,  REQ_SET_CURSOR, 5'd24, 7'd79,
          '{1'b0, 12'd0, 8'h00, 8'h00, 5'd24, 7'd79}},
        '{P_TYPED, REG_WIN_ROWS, 8'hFF,  REQ_CHAR, 5'd0, 7'd0,
          '{1'b1, 12'd3998, 8'hFF, 8'h07, 5'd0, 7'd0}},
        '{P_TYPED, REG_WIN_ROWS, CH_BS,  REQ_CHAR, 5'd0, 7'd0,
          '{1'b0, 12'd0, 8'h00, 8'h00, 5'd24, 7'd79}},
        '{P_TYPED, REG_WIN_ROWS, CH_TAB, REQ_CHAR, 5'd0, 7'd0,
          '{1'b0, 12'd0, 8'h00, 8'h00, 5'd0, 7'd3}},
        '{P_TYPED, REG_WIN_ROWS, CH_LF,  REQ_CHAR, 5'd0, 7'd0,
          '{1'b0, 12'd0, 8'h00, 8'h00, 5'd1, 7'd0}},
        '{P_TYPED, REG_WIN_ROWS, CH_LF,  REQ_SET_CURSOR, 5'd31, 7'd127,
          '{1'b0, 12'd0, 8'h00, 8'h00, 5'd6, 7'd47}},
        '{P_TYPED, REG_WIN_ROWS, CH_CR,  REQ_CHAR, 5'd0, 7'd0,
          '{1'b0, 12'd0, 8'h00, 8'h00, 5'd6, 7'd0}},
        '{P_TYPED, REG_WIN_ROWS, CH_NUL, REQ_CHAR, 5'd31, 7'd127,
          '{1'b0, 12'd0, 8'h00, 8'h00, 5'd6, 7'd0}},
        '{P_TYPED, REG_WIN_ROWS, 8'h01,  REQ_CHAR, 5'd0, 7'd0,
          '{1'b1, 12'd960, 8'h01, 8'h07, 5'd6, 7'd1}},
        '{P_TYPED, REG_WIN_ROWS, 8'h80,  REQ_CHAR, 5'd0, 7'd0,
          '{1'b1, 12'd962, 8'h80, 8'h07, 5'd6, 7'd2}},
        '{P_TYPED, REG_WIN_ROWS, 8'h00,  REQ_SET_CURSOR, 5'd0, 7'd0,
          '{1'b0, 12'd0, 8'h00, 8'h00, 5'd0, 7'd0}},
        '{P_CFG,   REG_WIN_ROWS, 8'd0,   REQ_CHAR, 5'd0, 7'd0, NO_CELL},
        '{P_CFG,   REG_WIN_COLS, 8'hFF,  REQ_CHAR, 5'd0, 7'd0, NO_CELL},
        '{P_CFG,   REG_ORG_ROW,  8'd24,  REQ_CHAR, 5'd0, 7'd0, NO_CELL},
        '{P_CFG,   REG_ORG_COL,  8'd5,   REQ_CHAR, 5'd0, 7'd0, NO_CELL},
        '{P_CFG,   REG_ATTR,     8'hA5,  REQ_CHAR, 5'd0, 7'd0, NO_CELL},
        '{P_TYPED, REG_WIN_ROWS, 8'h42,  REQ_CHAR, 5'd0, 7'd0,
          '{1'b1, 12'd3840, 8'h42, 8'hA5, 5'd0, 7'd1}},
        '{P_TYPED, REG_WIN_ROWS, CH_LF,  REQ_CHAR, 5'd0, 7'd0,
          '{1'b0, 12'd0, 8'h00, 8'h00, 5'd0, 7'd0}},
        '{P_TYPED, REG_WIN_ROWS, 8'h00,  REQ_SET_CURSOR, 5'd24, 7'd79,
          '{1'b0, 12'd0, 8'h00, 8'h00, 5'd0, 7'd79}},
        '{P_TYPED, REG_WIN_ROWS, 8'h43,  REQ_CHAR, 5'd0, 7'd0,
          '{1'b1, 12'd3998, 8'h43, 8'hA5, 5'd0, 7'd0}},
        '{P_CFG,   REG_WIN_ROWS, 8'd25,  REQ_CHAR, 5'd0, 7'd0, NO_CELL},
        '{P_CFG,   REG_WIN_COLS, 8'd80,  REQ_CHAR, 5'd0, 7'd0, NO_CELL},
        '{P_CFG,   REG_ORG_ROW,  8'd0,   REQ_CHAR, 5'd0, 7'd0, NO_CELL},
        '{P_TYPED, REG_WIN_ROWS, 8'h00,  REQ_SET_CURSOR, 5'd20, 7'd70,
          '{1'b0, 12'd0, 8'h00, 8'h00, 5'd20, 7'd70}},
        '{P_CFG,   REG_WIN_ROWS, 8'd10,  REQ_CHAR, 5'd0, 7'd0, NO_CELL},
        '{P_CFG,   REG_WIN_COLS, 8'd30,  REQ_CHAR, 5'd0, 7'd0, NO_CELL},
        '{P_CFG,   REG_ORG_ROW,  8'd3,   REQ_CHAR, 5'd0, 7'd0, NO_CELL},
        '{P_CFG,   REG_ORG_COL,  8'd50,  REQ_CHAR, 5'd0, 7'd0, NO_CELL},
        '{P_TYPED, REG_WIN_ROWS, 8'h44,  REQ_CHAR, 5'd0, 7'd0,
          '{1'b1, 12'd600, 8'h44, 8'hA5, 5'd0, 7'd11}},
        '{P_CFG,   REG_ORG_COL,  8'd51,  REQ_CHAR, 5'd0, 7'd0, NO_CELL},
        '{P_CFG,   REG_ORG_ROW,  8'd16,  REQ_CHAR, 5'd0, 7'd0, NO_CELL},
        '{P_TYPED, REG_WIN_ROWS, 8'h45,  REQ_CHAR, 5'd0, 7'd0,
          '{1'b1, 12'd22, 8'h45, 8'hA5, 5'd0, 7'd12}},
        '{P_PRED,  REG_WIN_ROWS, CH_BS,  REQ_CHAR, 5'd0, 7'd0, NO_CELL},
        '{P_PRED,  REG_WIN_ROWS, CH_TAB, REQ_CHAR, 5'd0, 7'd0, NO_CELL},
        '{P_CFG,   REG_WIN_COLS, 8'd0,   REQ_CHAR, 5'd0, 7'd0, NO_CELL},
        '{P_PRED,  REG_WIN_ROWS, 8'h46,  REQ_CHAR, 5'd0, 7'd0, NO_CELL},
        '{P_PRED,  REG_WIN_ROWS, CH_TAB, REQ_CHAR, 5'd0, 7'd0, NO_CELL},
        '{P_PRED,  REG_WIN_ROWS, CH_BS,  REQ_CHAR, 5'd0, 7'd0, NO_CELL}
    };

    task automatic report_mismatch(string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    function automatic int eff_extent(int v, int lim);
        if (v == 0)
            return 1;
        return (v > lim) ? lim : v;
    endfunction

    function automatic void advance_cells(int steps, int rows, int cols);
        cur_col += steps;
        while (cur_col >= cols)
        begin
            cur_col -= cols;
            cur_row = (cur_row + 1 >= rows) ? 0 : cur_row + 1;
        end
    endfunction

    // cursor/cell prediction for one accepted request
    function automatic cell_result_t next_cell(logic rq, logic [7:0] code,
                                               logic [ROW_W-1:0] srow,
                                               logic [COL_W-1:0] scol);
        cell_result_t r;
        int rows;
        int cols;
        int orow;
        int ocol;
        r = NO_CELL;
        rows = eff_extent(int'(win_rows_reg), SCREEN_ROWS);
        cols = eff_extent(int'(win_cols_reg), SCREEN_COLS);
        orow = (int'(org_row_reg) + rows > SCREEN_ROWS) ? 0 : int'(org_row_reg);
        ocol = (int'(org_col_reg) + cols > SCREEN_COLS) ? 0 : int'(org_col_reg);
        if (cur_row >= rows)
            cur_row = cur_row % rows;
        if (cur_col >= cols)
            cur_col = cur_col % cols;
        if (rq == REQ_SET_CURSOR)
        begin
            cur_row = int'(srow) % rows;
            cur_col = int'(scol) % cols;
        end
        else
        begin
            case (code)
                CH_LF:
                begin
                    cur_row = (cur_row + 1 >= rows) ? 0 : cur_row + 1;
                    cur_col = 0;
                end
                CH_CR:  cur_col = 0;
                CH_BS:
                begin
                    if (cur_col > 0)
                        cur_col--;
                    else
                    begin
                        cur_col = cols - 1;
                        cur_row = (cur_row == 0) ? rows - 1 : cur_row - 1;
                    end
                end
                CH_TAB: advance_cells(TAB_STEP, rows, cols);
                CH_NUL: ;
                default:
                begin
                    r.wr   = 1'b1;
                    r.ofs  = OFS_W'(((orow + cur_row) * SCREEN_COLS + ocol + cur_col) * 2);
                    r.ch   = code;
                    r.attr = attr_reg;
                    advance_cells(1, rows, cols);
                end
            endcase
        end
        r.row = ROW_W'(cur_row);
        r.col = COL_W'(cur_col);
        return r;
    endfunction

    task automatic offer(logic rq, logic [7:0] code, logic [ROW_W-1:0] srow,
                         logic [COL_W-1:0] scol, bit typed, cell_result_t typed_want);
        cell_result_t pred;
        in_valid  <= 1'b1;
        req_type  <= rq;
        char_code <= code;
        set_row   <= srow;
        set_col   <= scol;
        do
            @(posedge clk);
        while (in_stall);
        pred = next_cell(rq, code, srow, scol);
        expected_cells.push_back(typed ? typed_want : pred);
        n_items++;
    endtask

    task automatic pause(int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic int idle_gap();
        int n;
        n = 0;
        while (n < 8 && $urandom_range(99) < send_idle_pct)
            n++;
        return n;
    endfunction

    task automatic wait_idle();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (expected_cells.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [7:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_WIN_ROWS: win_rows_reg = data[ROW_W-1:0];
            REG_WIN_COLS: win_cols_reg = data[COL_W-1:0];
            REG_ORG_ROW:  org_row_reg  = data[ROW_W-1:0];
            REG_ORG_COL:  org_col_reg  = data[COL_W-1:0];
            REG_ATTR:     attr_reg     = data;
            default: ;
        endcase
    endtask

    // result checker and receiver stall generation
    always @(posedge clk)
    begin : receiver
        cell_result_t got;
        cell_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{write_valid, cell_offset, cell_char, cell_attr, cursor_row, cursor_col};
            if (expected_cells.size() == 0)
                report_mismatch("result arrived with no request pending");
            else
            begin
                want = expected_cells.pop_front();
                n_checked++;
                if (got.wr)
                    n_writes++;
                if (got.wr !== want.wr)
                    report_mismatch($sformatf("result %0d write_valid %0h want %0h",
                                              n_checked, got.wr, want.wr));
                if (got.ofs !== want.ofs)
                    report_mismatch($sformatf("result %0d cell_offset %0d want %0d",
                                              n_checked, got.ofs, want.ofs));
                if (got.ch !== want.ch)
                    report_mismatch($sformatf("result %0d cell_char %0h want %0h",
                                              n_checked, got.ch, want.ch));
                if (got.attr !== want.attr)
                    report_mismatch($sformatf("result %0d cell_attr %0h want %0h",
                                              n_checked, got.attr, want.attr));
                if (got.row !== want.row)
                    report_mismatch($sformatf("result %0d cursor_row %0d want %0d",
                                              n_checked, got.row, want.row));
                if (got.col !== want.col)
                    report_mismatch($sformatf("result %0d cursor_col %0d want %0d",
                                              n_checked, got.col, want.col));
            end
        end
        if (hold_asks != holds_done)
        begin
            holds_done++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    initial
    begin
        #10_000_000;
        $display("FAIL text_window_console_cursor_top");
        $finish;
    end

    initial
    begin : stimulus
        int p;
        int k;
        int r;
        logic              rq;
        logic [7:0]        code;
        logic [ROW_W-1:0]  srow;
        logic [COL_W-1:0]  scol;
        logic [7:0]        setting [5];

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == P_CFG)
            begin
                wait_idle();
                write_reg(plan[i].idx, plan[i].val);
            end
            else
            begin
                offer(plan[i].req, plan[i].val, plan[i].srow, plan[i].scol,
                      plan[i].kind == P_TYPED, plan[i].want);
                pause(idle_gap());
            end
        end
        n_settings++;

        for (p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            case (p)
                0: setting = '{8'd25, 8'd80, 8'd0, 8'd0, 8'h07};
                1: setting = '{8'd0, 8'd0, 8'd24, 8'd79, 8'h00};
                2: setting = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
                3: setting = '{8'd1, 8'd80, 8'd24, 8'd0, 8'h70};
                default:
                    foreach (setting[j])
                        setting[j] = 8'($urandom_range(0, 255));
            endcase
            write_reg(REG_WIN_ROWS, setting[0]);
            write_reg(REG_WIN_COLS, setting[1]);
            write_reg(REG_ORG_ROW,  setting[2]);
            write_reg(REG_ORG_COL,  setting[3]);
            write_reg(REG_ATTR,     setting[4]);
            n_settings++;

            if (p < 3)
            begin
                send_idle_pct = 34;
                recv_idle_pct = 47;
            end
            else if (p < 6)
            begin
                send_idle_pct = 47;
                recv_idle_pct = 34;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // long output hold-off while requests keep coming
            if (p == 1 || p == 6)
                hold_asks++;

            for (k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                r    = $urandom_range(99);
                rq   = REQ_CHAR;
                srow = ROW_W'($urandom_range(0, 31));
                scol = COL_W'($urandom_range(0, 127));
                code = 8'($urandom_range(8'h20, 8'h7E));
                if (r < 10)
                begin
                    rq   = REQ_SET_CURSOR;
                    code = 8'($urandom_range(0, 255));
                end
                else if (r < 25)
                begin
                    case ($urandom_range(4))
                        0: code = CH_LF;
                        1: code = CH_CR;
                        2: code = CH_BS;
                        3: code = CH_TAB;
                        default: code = CH_NUL;
                    endcase
                end
                else if (r < 35)
                    code = 8'($urandom_range(0, 255));
                offer(rq, code, srow, scol, 1'b0, NO_CELL);
                pause(idle_gap());
            end
        end

        wait_idle();
        if (expected_cells.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_cells.size()));

        $display("Sent %0d requests under %0d window settings with varied idle patterns.",
                 n_items, n_settings);
        $display("Checked %0d results, %0d of them cell writes; %0d mismatches.",
                 n_checked, n_writes, errors);
        if (errors == 0)
            $display("PASS text_window_console_cursor_top");
        else
            $display("FAIL text_window_console_cursor_top");
        $finish;
    end

endmodule

/* text_window_console_cursor_top.f */
rtl/twcc_pkg.sv
rtl/twcc_cfg.sv
rtl/twcc_ctrl.sv
rtl/twcc_dp.sv
rtl/text_window_console_cursor_top.sv
tb/text_window_console_cursor_top_tb.sv
